@@ hw/rtl/acd_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio channel downmix package
// Sample and frame types, configuration indexes and the fixed-point
// constants of the 5.1 to stereo downmix.
// ----------------------------------------------------------------------------
package acd_pkg;

  localparam int unsigned SampleBits = 24;
  localparam int unsigned NumCh      = 8;
  localparam int unsigned CountBits  = 4;
  localparam int unsigned CfgIdxBits = 1;

  // Centre coefficient 0.707 in Q1.15.
  localparam int unsigned CoefBits   = 17;
  localparam logic [15:0] CoefCenter = 16'd23167;

  // Centre product in units of 2^-15 LSB, downmix accumulator in units of 2^-16 LSB.
  localparam int unsigned CprodBits  = SampleBits + CoefBits;
  localparam int unsigned AccBits    = SampleBits + 18;
  localparam int unsigned AccShift   = 16;
  localparam int unsigned SumBits    = SampleBits + 1;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [CountBits-1:0]         count_t;
  typedef logic [CfgIdxBits-1:0]        cfg_idx_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SOURCE_CHANNELS = 1'b0,
    CFG_TARGET_CHANNELS = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_GENERIC     = 2'd0,
    MODE_DOWNMIX     = 2'd1,
    MODE_MONO_UP     = 2'd2,
    MODE_STEREO_DOWN = 2'd3
  } mix_mode_e;

  typedef struct packed {
    sample_t in_ch0;
    sample_t in_ch1;
    sample_t in_ch2;
    sample_t in_ch3;
    sample_t in_ch4;
    sample_t in_ch5;
    sample_t in_ch6;
    sample_t in_ch7;
  } frame_in_t;

  typedef struct packed {
    sample_t out_ch0;
    sample_t out_ch1;
    sample_t out_ch2;
    sample_t out_ch3;
    sample_t out_ch4;
    sample_t out_ch5;
    sample_t out_ch6;
    sample_t out_ch7;
  } frame_out_t;

endpackage

@@ hw/rtl/audio_channel_downmix_unit.sv @@
// ----------------------------------------------------------------------------
// Audio channel downmix unit
// Converts one multichannel audio frame per word between channel layouts:
// copy, 5.1 to stereo downmix with saturation, mono to stereo, stereo to
// mono average, and copy with zero padding for every other pair.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_data_i   (frame_in_t)
// out       output     out_valid_o / out_stall_i  out_data_o  (frame_out_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// Four register stages: input and layout decode, centre multiply, downmix
// sums, saturation and lane select. A word accepted into the input stage
// passes through the multiply and sum stages to the output register, and one
// word is taken per cycle when the output is not stalled.
// Each stage holds its word while the next one is full and stalled, so a
// stall reaches in_stall_o only once every stage is occupied.
// Reset empties the pipeline and sets both channel counts to two.
// ----------------------------------------------------------------------------
module audio_channel_downmix_unit
  import acd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_idx_t   cfg_idx_i,
  input  count_t     cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  frame_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output frame_out_t out_data_o
);

  count_t src_cnt_q, dst_cnt_q;
  count_t src_eff, dst_eff;

  sample_t   in_smp [NumCh];
  mix_mode_e mode_d;
  logic [NumCh-1:0] keep_d;

  logic rdy0, rdy1, rdy2, rdy3;

  logic v0_q, v1_q, v2_q, v3_q;
  sample_t smp0_q [NumCh];
  sample_t smp1_q [NumCh];
  sample_t smp2_q [NumCh];
  mix_mode_e mode0_q, mode1_q, mode2_q;
  logic [NumCh-1:0] keep0_q, keep1_q, keep2_q;

  logic signed [CoefBits-1:0]  coef;
  logic signed [CprodBits-1:0] cprod_d, cprod1_q;

  logic signed [AccBits-1:0] acc_l_d, acc_r_d, acc_l2_q, acc_r2_q;
  logic signed [SumBits-1:0] sum_d, sum2_q;

  logic signed [AccBits-AccShift-1:0] sh_l, sh_r;
  sample_t sat_l, sat_r;
  sample_t res_d [NumCh];
  sample_t res_q [NumCh];

  function automatic count_t eff_count(count_t n);
    count_t r;
    r = n;
    if (n == '0) begin
      r = count_t'(1);
    end else if (n > count_t'(NumCh)) begin
      r = count_t'(NumCh);
    end
    return r;
  endfunction

  function automatic sample_t saturate(logic signed [AccBits-AccShift-1:0] v);
    sample_t r;
    r = v[SampleBits-1:0];
    if (v > $signed({{(AccBits-AccShift-SampleBits+1){1'b0}}, {(SampleBits-1){1'b1}}})) begin
      r = {1'b0, {(SampleBits-1){1'b1}}};
    end else if (v < $signed({{(AccBits-AccShift-SampleBits+1){1'b1}},
                              {(SampleBits-1){1'b0}}})) begin
      r = {1'b1, {(SampleBits-1){1'b0}}};
    end
    return r;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q <= count_t'(2);
      dst_cnt_q <= count_t'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SOURCE_CHANNELS: src_cnt_q <= cfg_wdata_i;
        CFG_TARGET_CHANNELS: dst_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage ready chain: a stage may load when it is empty or drains itself.
  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign rdy0       = !v0_q || rdy1;
  assign in_stall_o = !rdy0;

  // Layout decode ahead of stage 0.
  always_comb begin
    in_smp[0] = in_data_i.in_ch0;
    in_smp[1] = in_data_i.in_ch1;
    in_smp[2] = in_data_i.in_ch2;
    in_smp[3] = in_data_i.in_ch3;
    in_smp[4] = in_data_i.in_ch4;
    in_smp[5] = in_data_i.in_ch5;
    in_smp[6] = in_data_i.in_ch6;
    in_smp[7] = in_data_i.in_ch7;

    src_eff = eff_count(src_cnt_q);
    dst_eff = eff_count(dst_cnt_q);

    if (src_eff == count_t'(6) && dst_eff == count_t'(2)) begin
      mode_d = MODE_DOWNMIX;
    end else if (src_eff == count_t'(1) && dst_eff == count_t'(2)) begin
      mode_d = MODE_MONO_UP;
    end else if (src_eff == count_t'(2) && dst_eff == count_t'(1)) begin
      mode_d = MODE_STEREO_DOWN;
    end else begin
      mode_d = MODE_GENERIC;
    end

    for (int i = 0; i < NumCh; i++) begin
      keep_d[i] = (count_t'(i) < src_eff) && (count_t'(i) < dst_eff);
    end
  end

  // Stage 0: input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      smp0_q  <= in_smp;
      mode0_q <= mode_d;
      keep0_q <= keep_d;
    end
  end

  // Stage 1: centre times 0.707.
  assign coef    = $signed({1'b0, CoefCenter});
  assign cprod_d = CprodBits'(smp0_q[2]) * CprodBits'(coef);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      smp1_q   <= smp0_q;
      mode1_q  <= mode0_q;
      keep1_q  <= keep0_q;
      cprod1_q <= cprod_d;
    end
  end

  // Stage 2: downmix sums with the rounding half added, and the stereo sum.
  always_comb begin
    acc_l_d = (AccBits'(smp1_q[0]) <<< 16) + (AccBits'(cprod1_q) <<< 1)
            + (AccBits'(smp1_q[4]) <<< 15) + AccBits'(32768);
    acc_r_d = (AccBits'(smp1_q[1]) <<< 16) + (AccBits'(cprod1_q) <<< 1)
            + (AccBits'(smp1_q[5]) <<< 15) + AccBits'(32768);
    sum_d   = SumBits'(smp1_q[0]) + SumBits'(smp1_q[1]) + SumBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      smp2_q   <= smp1_q;
      mode2_q  <= mode1_q;
      keep2_q  <= keep1_q;
      acc_l2_q <= acc_l_d;
      acc_r2_q <= acc_r_d;
      sum2_q   <= sum_d;
    end
  end

  // Stage 3: arithmetic shift floors, then saturation and lane select.
  always_comb begin
    sh_l  = acc_l2_q[AccBits-1:AccShift];
    sh_r  = acc_r2_q[AccBits-1:AccShift];
    sat_l = saturate(sh_l);
    sat_r = saturate(sh_r);
    for (int i = 0; i < NumCh; i++) begin
      res_d[i] = '0;
    end
    case (mode2_q)
      MODE_DOWNMIX: begin
        res_d[0] = sat_l;
        res_d[1] = sat_r;
      end
      MODE_MONO_UP: begin
        res_d[0] = smp2_q[0];
        res_d[1] = smp2_q[0];
      end
      MODE_STEREO_DOWN: begin
        res_d[0] = sum2_q[SumBits-1:1];
      end
      default: begin
        for (int i = 0; i < NumCh; i++) begin
          res_d[i] = keep2_q[i] ? smp2_q[i] : '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = v3_q;
  assign out_data_o.out_ch0 = res_q[0];
  assign out_data_o.out_ch1 = res_q[1];
  assign out_data_o.out_ch2 = res_q[2];
  assign out_data_o.out_ch3 = res_q[3];
  assign out_data_o.out_ch4 = res_q[4];
  assign out_data_o.out_ch5 = res_q[5];
  assign out_data_o.out_ch6 = res_q[6];
  assign out_data_o.out_ch7 = res_q[7];

`ifndef SYNTHESIS
  // The input side is stalled only when every stage holds a word.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && v1_q && v2_q && v3_q))
    else $error("input stalled while a pipeline stage is empty");

  // A fresh output word always comes from a valid word in the stage before.
  a_out_from_stage2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v3_q ##1 v3_q) |-> $past(v2_q))
    else $error("output word appeared without a word in the sum stage");

  // A held stage-2 word is not lost while the output is stalled.
  a_stage2_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && v3_q && out_stall_i) |=> v2_q)
    else $error("sum stage word dropped during an output stall");
`endif

endmodule
